FILE: rtl/rte_pkg.sv
`timescale 1ns / 1ps

package rte_pkg;

    // ASCII codes used by the escaper
    localparam logic [6:0] CH_BSLASH = 7'h5C;
    localparam logic [6:0] CH_LBRACE = 7'h7B;
    localparam logic [6:0] CH_RBRACE = 7'h7D;
    localparam logic [6:0] CH_TAB    = 7'h09;
    localparam logic [6:0] CH_LF     = 7'h0A;
    localparam logic [6:0] CH_CR     = 7'h0D;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_MINUS  = 7'h2D;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_QMARK  = 7'h3F;
    localparam logic [6:0] CH_A      = 7'h61;
    localparam logic [6:0] CH_B      = 7'h62;
    localparam logic [6:0] CH_E      = 7'h65;
    localparam logic [6:0] CH_I      = 7'h69;
    localparam logic [6:0] CH_L      = 7'h6C;
    localparam logic [6:0] CH_N      = 7'h6E;
    localparam logic [6:0] CH_T      = 7'h74;
    localparam logic [6:0] CH_U      = 7'h75;

    localparam int ASCII_LIMIT = 128;

    typedef enum logic [2:0] {
        KIND_PLAIN = 3'd0,
        KIND_ESC   = 3'd1,
        KIND_TAB   = 3'd2,
        KIND_LINE  = 3'd3,
        KIND_UNI   = 3'd4
    } kind_t;

    // classified code unit, handed to the serializer
    typedef struct packed {
        kind_t       kind;
        logic [6:0]  ch;
        logic        neg;
        logic [15:0] mag;
        logic [2:0]  exp;   // index of the leading decimal digit
    } rte_item_t;

    // one output character
    typedef struct packed {
        logic [6:0] ch;
        logic       unit_end;
        logic       text_end;
    } rte_char_t;

    // d * 10^e, d up to 10; fits 17 bits
    function automatic logic [16:0] dec_mult(input logic [2:0] e, input logic [3:0] d);
        logic [16:0] r;
        unique case (e)
            3'd0:    r = 17'(d);
            3'd1:    r = 17'(d) * 17'd10;
            3'd2:    r = 17'(d) * 17'd100;
            3'd3:    r = 17'(d) * 17'd1000;
            3'd4:    r = 17'(d) * 17'd10000;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // characters of the fixed keywords
    function automatic logic [6:0] kw_char(input kind_t kind, input logic [2:0] step);
        logic [6:0] c;
        c = CH_SPACE;
        unique case (kind)
            KIND_TAB:
            begin
                case (step)
                    3'd0:    c = CH_BSLASH;
                    3'd1:    c = CH_T;
                    3'd2:    c = CH_A;
                    3'd3:    c = CH_B;
                    default: c = CH_SPACE;
                endcase
            end
            KIND_LINE:
            begin
                case (step)
                    3'd0:    c = CH_BSLASH;
                    3'd1:    c = CH_L;
                    3'd2:    c = CH_I;
                    3'd3:    c = CH_N;
                    3'd4:    c = CH_E;
                    default: c = CH_SPACE;
                endcase
            end
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    // step index of the final character for the fixed-text kinds
    function automatic logic [2:0] text_last(input kind_t kind);
        logic [2:0] n;
        unique case (kind)
            KIND_ESC:  n = 3'd1;
            KIND_TAB:  n = 3'd4;
            KIND_LINE: n = 3'd5;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/rte_classify.sv
`timescale 1ns / 1ps

module rte_classify
(
    input  logic [15:0]       code_unit,
    output rte_pkg::rte_item_t item
);

    logic [15:0] mag;
    logic        neg;

    always_comb
    begin
        neg = code_unit[15];
        mag = neg ? 16'(17'h10000 - {1'b0, code_unit}) : code_unit;
    end

    always_comb
    begin
        item.ch  = code_unit[6:0];
        item.neg = neg;
        item.mag = mag;

        if (code_unit == {9'd0, rte_pkg::CH_BSLASH} ||
            code_unit == {9'd0, rte_pkg::CH_LBRACE} ||
            code_unit == {9'd0, rte_pkg::CH_RBRACE})
            item.kind = rte_pkg::KIND_ESC;
        else if (code_unit == {9'd0, rte_pkg::CH_TAB})
            item.kind = rte_pkg::KIND_TAB;
        else if (code_unit == {9'd0, rte_pkg::CH_LF} || code_unit == {9'd0, rte_pkg::CH_CR})
            item.kind = rte_pkg::KIND_LINE;
        else if (code_unit < 16'(rte_pkg::ASCII_LIMIT))
            item.kind = rte_pkg::KIND_PLAIN;
        else
            item.kind = rte_pkg::KIND_UNI;

        if ({1'b0, mag} >= rte_pkg::dec_mult(3'd4, 4'd1))
            item.exp = 3'd4;
        else if ({1'b0, mag} >= rte_pkg::dec_mult(3'd3, 4'd1))
            item.exp = 3'd3;
        else if ({1'b0, mag} >= rte_pkg::dec_mult(3'd2, 4'd1))
            item.exp = 3'd2;
        else if ({1'b0, mag} >= rte_pkg::dec_mult(3'd1, 4'd1))
            item.exp = 3'd1;
        else
            item.exp = 3'd0;
    end

endmodule

FILE: rtl/rte_serializer.sv
`timescale 1ns / 1ps

module rte_serializer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rte_pkg::rte_item_t item,
    input  logic               in_last,
    output logic               in_stall,
    input  logic               adv,
    output logic               push,
    output rte_pkg::rte_char_t out_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_TEXT   = 5'b00010,
        ST_PREFIX = 5'b00100,
        ST_DIGIT  = 5'b01000,
        ST_QMARK  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    rte_pkg::kind_t kind_reg;
    logic [6:0]     ch_reg;
    logic           neg_reg;
    logic [15:0]    rem_reg, rem_next;
    logic [2:0]     exp_reg, exp_next;
    logic [2:0]     step_reg, step_next;
    logic           last_reg;

    logic           load;
    logic           fin;
    logic [6:0]     cur_ch;
    logic [3:0]     dig;
    logic [16:0]    rem_sub;

    // leading digit of the remainder at the current decimal place
    always_comb
    begin
        dig = 4'd0;
        for (int d = 1; d <= 9; d++)
        begin
            if ({1'b0, rem_reg} >= rte_pkg::dec_mult(exp_reg, 4'(d)))
                dig = 4'(d);
        end
        rem_sub = {1'b0, rem_reg} - rte_pkg::dec_mult(exp_reg, dig);
    end

    always_comb
    begin
        cur_ch     = rte_pkg::CH_QMARK;
        fin        = 1'b0;
        state_next = state_reg;
        step_next  = step_reg;
        exp_next   = exp_reg;
        rem_next   = rem_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cur_ch = rte_pkg::CH_QMARK;
            end
            ST_TEXT:
            begin
                if (kind_reg == rte_pkg::KIND_PLAIN)
                    cur_ch = ch_reg;
                else if (kind_reg == rte_pkg::KIND_ESC)
                    cur_ch = (step_reg == 3'd0) ? rte_pkg::CH_BSLASH : ch_reg;
                else
                    cur_ch = rte_pkg::kw_char(kind_reg, step_reg);
                fin       = (step_reg == rte_pkg::text_last(kind_reg));
                step_next = step_reg + 3'd1;
            end
            ST_PREFIX:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:    cur_ch = rte_pkg::CH_BSLASH;
                    3'd1:    cur_ch = rte_pkg::CH_U;
                    default: cur_ch = rte_pkg::CH_MINUS;
                endcase
                if ((step_reg == 3'd1 && !neg_reg) || step_reg == 3'd2)
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                cur_ch   = rte_pkg::CH_ZERO + {3'd0, dig};
                rem_next = rem_sub[15:0];
                exp_next = exp_reg - 3'd1;
                if (exp_reg == 3'd0)
                    state_next = ST_QMARK;
            end
            ST_QMARK:
            begin
                cur_ch = rte_pkg::CH_QMARK;
                fin    = 1'b1;
            end
            default:
            begin
                cur_ch = rte_pkg::CH_QMARK;
            end
        endcase

        if (fin)
            state_next = ST_IDLE;
    end

    assign push     = (state_reg != ST_IDLE) && adv;
    assign in_stall = !((state_reg == ST_IDLE) || (fin && adv));
    assign load     = in_valid && !in_stall;

    assign out_data.ch       = cur_ch;
    assign out_data.unit_end = fin;
    assign out_data.text_end = fin && last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else if (load)
        begin
            state_reg <= (item.kind == rte_pkg::KIND_UNI) ? ST_PREFIX : ST_TEXT;
        end
        else if (push)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= item.kind;
            ch_reg   <= item.ch;
            neg_reg  <= item.neg;
            rem_reg  <= item.mag;
            exp_reg  <= item.exp;
            step_reg <= 3'd0;
            last_reg <= in_last;
        end
        else if (push)
        begin
            rem_reg  <= rem_next;
            exp_reg  <= exp_next;
            step_reg <= step_next;
        end
    end

    // remainder never carries more digits than places left
    a_rem_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIGIT |-> {1'b0, rem_reg} < rte_pkg::dec_mult(exp_reg, 4'd10))
        else $error("remainder exceeds remaining decimal places");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push && fin && !load |=> state_reg == ST_IDLE)
        else $error("serializer did not go idle after final character");

    a_minus_only_neg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREFIX && step_reg == 3'd2 |-> neg_reg)
        else $error("minus sign on a non-negative unit");

    a_digit_exp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIGIT |-> exp_reg <= 3'd4)
        else $error("decimal place out of range");

endmodule

FILE: rtl/rte_out_reg.sv
`timescale 1ns / 1ps

module rte_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rte_pkg::rte_char_t in_data,
    output logic               adv,
    output logic               out_valid,
    input  logic               out_stall,
    output rte_pkg::rte_char_t out_data
);

    logic               valid_reg;
    rte_pkg::rte_char_t data_reg;

    // register is free when empty or being drained this cycle
    assign adv = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (adv && push)
            data_reg <= in_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/rtf_text_escape_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------
// input    | in_valid / in_stall  | code_unit[15:0], last_unit
// output   | out_valid / out_stall| out_char[6:0], last_of_unit, end_of_text
//
// One character per cycle unless out_stall holds the output register. A code
// unit expanding to N characters (1 to 9) holds the serializer; the next
// request is taken in the cycle its predecessor's final character moves to
// the output register. Decimal digits: per-cycle compare/subtract vs 10^k.
// Reset clears only the control state; the output register empties.
// out_stall reaches in_stall combinationally through the output register.

module rtf_text_escape_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] code_unit,
    input  logic        last_unit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_char,
    output logic        last_of_unit,
    output logic        end_of_text
);

    rte_pkg::rte_item_t item;
    rte_pkg::rte_char_t ser_char;
    rte_pkg::rte_char_t out_data;
    logic               push;
    logic               adv;

    rte_classify u_classify
    (
        .code_unit (code_unit),
        .item      (item)
    );

    rte_serializer u_serializer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .item     (item),
        .in_last  (last_unit),
        .in_stall (in_stall),
        .adv      (adv),
        .push     (push),
        .out_data (ser_char)
    );

    rte_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_data   (ser_char),
        .adv       (adv),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign out_char     = out_data.ch;
    assign last_of_unit = out_data.unit_end;
    assign end_of_text  = out_data.text_end;

endmodule
